// File: hw/rtl/rls_pkg.sv
// Shared types, constants and helpers for the two-parameter RLS estimator.
// Used by rls_div and rls_two_parameter_estimator; depends on nothing.
`default_nettype none

package rls_pkg;

    localparam int DIV_W   = 64;
    localparam int DIV_CNT = 7;

    // Register indexes of the configuration port.
    localparam logic [1:0] CFG_FORGET = 2'd0;
    localparam logic [1:0] CFG_INITCOV = 2'd1;
    localparam logic [1:0] CFG_MINDEN = 2'd2;

    localparam logic [16:0] FORGET_RESET  = 17'd65536;
    localparam logic [16:0] FORGET_MAX    = 17'd65536;
    localparam logic [30:0] INITCOV_RESET = 31'd65536000;
    localparam logic [16:0] MINDEN_RESET  = 17'd1;

    // Covariance entries are scaled by 65536 before the divide by lambda.
    localparam int LAMBDA_SHIFT = 16;

    typedef struct packed {
        logic                    start;
        logic signed [DIV_W-1:0] dividend;
        logic signed [31:0]      divisor;
    } div_req_t;

    function automatic logic fits32(input logic signed [63:0] v);
        logic [32:0] top;
        top = v[63:31];
        return (top == {33{1'b0}}) || (top == {33{1'b1}});
    endfunction

endpackage

`default_nettype wire

// File: hw/rtl/rls_two_parameter_estimator.sv
// Top level of the two-parameter RLS estimator: sequencer, state and ports.
// Depends on rls_pkg, rls_mul and rls_div.
//
// An update request runs fourteen multiplies on the shared multiplier and six
// divides on the shared divider (one quotient bit per cycle), plus range checks
// and the commit. A rejected update finishes as soon as its failing check is
// reached. A restart request skips the arithmetic and goes straight to ST_FIN.
// The input is not ready while a request is in work; a finished result waits
// in the output register while the next request is taken. Configuration is
// written through cfg_* at any time the block is idle.
`default_nettype none

module rls_two_parameter_estimator #(
    parameter int FRAC_BITS = 16
) (
    input  wire logic         clk,
    input  wire logic         rst_n,
    input  wire logic         s_tvalid,
    output logic              s_tready,
    input  wire logic [95:0]  s_tdata,   // regressor_a, regressor_b, measured
    input  wire logic [0:0]   s_tuser,   // op
    output logic              m_tvalid,
    input  wire logic         m_tready,
    output logic [127:0]      m_tdata,   // predicted, pred_error, estimate_a, estimate_b
    output logic [0:0]        m_tuser,   // status
    input  wire logic         cfg_valid,
    output logic              cfg_ready,
    input  wire logic [1:0]   cfg_index,
    input  wire logic [30:0]  cfg_data
);

    localparam logic [2:0] ST_IDLE  = 3'd0;
    localparam logic [2:0] ST_ISSUE = 3'd1;
    localparam logic [2:0] ST_POST  = 3'd2;
    localparam logic [2:0] ST_WAIT  = 3'd3;
    localparam logic [2:0] ST_FIN   = 3'd4;

    localparam logic [4:0] STEP_PRED = 5'd1;
    localparam logic [4:0] STEP_P0   = 5'd3;
    localparam logic [4:0] STEP_P1   = 5'd5;
    localparam logic [4:0] STEP_D    = 5'd7;
    localparam logic [4:0] STEP_CHK  = 5'd8;
    localparam logic [4:0] STEP_G0   = 5'd9;
    localparam logic [4:0] STEP_G1   = 5'd10;
    localparam logic [4:0] STEP_NA   = 5'd11;
    localparam logic [4:0] STEP_NB   = 5'd12;
    localparam logic [4:0] STEP_C00  = 5'd13;
    localparam logic [4:0] STEP_C01  = 5'd14;
    localparam logic [4:0] STEP_C10  = 5'd15;
    localparam logic [4:0] STEP_C11  = 5'd16;
    localparam logic [4:0] STEP_N00  = 5'd17;
    localparam logic [4:0] STEP_N01  = 5'd18;
    localparam logic [4:0] STEP_N10  = 5'd19;
    localparam logic [4:0] STEP_N11  = 5'd20;

    logic [2:0]  state_reg;
    logic [4:0]  step_reg;
    logic        restart_reg;
    logic        reject_reg;

    logic [16:0] forget_reg;
    logic [30:0] initcov_reg;
    logic [16:0] minden_reg;

    logic signed [31:0] pa_reg, pb_reg, cda_reg, cod_reg, cdb_reg;
    logic signed [31:0] a_reg, b_reg, y_reg;
    logic signed [63:0] acc_reg;
    logic signed [31:0] pred_reg, err_reg, p0_reg, p1_reg, d_reg, g0_reg, g1_reg;
    logic signed [31:0] na_reg, nb_reg, c00_reg, c01_reg, c10_reg, c11_reg;
    logic signed [31:0] n00_reg, n01_reg, n10_reg, n11_reg;

    logic               out_valid_reg;
    logic signed [31:0] out_pred_reg, out_err_reg, out_ea_reg, out_eb_reg;
    logic               out_status_reg;

    logic signed [31:0] mx, my;
    logic signed [63:0] q;
    rls_pkg::div_req_t  dreq;
    logic               div_done;
    logic signed [63:0] quo;

    logic               is_div, is_chk, do_post;
    logic signed [63:0] sum, errw, d2, ad, res, lam, dsub, nsum;
    logic               fail;
    logic               accept;

    rls_mul #(.FRAC_BITS(FRAC_BITS)) u_mul (
        .clk (clk),
        .x   (mx),
        .y   (my),
        .q   (q)
    );

    rls_div u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .req      (dreq),
        .done     (div_done),
        .quotient (quo)
    );

    assign accept    = s_tvalid && s_tready;
    assign s_tready  = state_reg == ST_IDLE;
    assign cfg_ready = 1'b1;
    assign is_div    = (step_reg == STEP_G0) || (step_reg == STEP_G1) ||
                       (step_reg >= STEP_N00);
    assign is_chk    = step_reg == STEP_CHK;
    assign lam       = 64'(({47'd0, forget_reg} << FRAC_BITS) >> 16);

    always_comb
    begin
        unique case (step_reg)
            5'd0:     begin mx = a_reg;   my = pa_reg;  end
            5'd1:     begin mx = b_reg;   my = pb_reg;  end
            5'd2:     begin mx = cda_reg; my = a_reg;   end
            5'd3:     begin mx = cod_reg; my = b_reg;   end
            5'd4:     begin mx = cod_reg; my = a_reg;   end
            5'd5:     begin mx = cdb_reg; my = b_reg;   end
            5'd6:     begin mx = a_reg;   my = p0_reg;  end
            5'd7:     begin mx = b_reg;   my = p1_reg;  end
            STEP_NA:  begin mx = g0_reg;  my = err_reg; end
            STEP_NB:  begin mx = g1_reg;  my = err_reg; end
            STEP_C00: begin mx = g0_reg;  my = p0_reg;  end
            STEP_C01: begin mx = g0_reg;  my = p1_reg;  end
            STEP_C10: begin mx = g1_reg;  my = p0_reg;  end
            STEP_C11: begin mx = g1_reg;  my = p1_reg;  end
            default:  begin mx = '0;      my = '0;      end
        endcase
    end

    always_comb
    begin
        dsub = '0;
        unique case (step_reg)
            STEP_N00: dsub = 64'(cda_reg) - 64'(c00_reg);
            STEP_N01: dsub = 64'(cod_reg) - 64'(c01_reg);
            STEP_N10: dsub = 64'(cod_reg) - 64'(c10_reg);
            STEP_N11: dsub = 64'(cdb_reg) - 64'(c11_reg);
            default:  dsub = '0;
        endcase
        dreq.start = (state_reg == ST_ISSUE) && is_div;
        if (step_reg == STEP_G0 || step_reg == STEP_G1)
        begin
            dreq.dividend = 64'(step_reg == STEP_G0 ? p0_reg : p1_reg) <<< FRAC_BITS;
            dreq.divisor  = d_reg;
        end
        else
        begin
            dreq.dividend = dsub <<< rls_pkg::LAMBDA_SHIFT;
            dreq.divisor  = $signed({15'd0, forget_reg});
        end
    end

    // Result of the current step and whether it breaks a range check.
    always_comb
    begin
        sum  = acc_reg + q;
        errw = 64'(y_reg) - sum;
        d2   = 64'(d_reg) + lam;
        ad   = d2[63] ? -d2 : d2;
        res  = sum;
        fail = 1'b0;
        unique case (step_reg)
            STEP_PRED: fail = !rls_pkg::fits32(sum) || !rls_pkg::fits32(errw);
            STEP_P0, STEP_P1, STEP_D: fail = !rls_pkg::fits32(sum);
            STEP_CHK:
            begin
                res  = d2;
                fail = !rls_pkg::fits32(d2) || (d2 == 64'sd0) ||
                       ($unsigned(ad) < {47'd0, minden_reg});
            end
            STEP_G0, STEP_G1, STEP_N00, STEP_N01, STEP_N10, STEP_N11:
            begin
                res  = quo;
                fail = !rls_pkg::fits32(quo);
            end
            STEP_NA:
            begin
                res  = 64'(pa_reg) + q;
                fail = !rls_pkg::fits32(res);
            end
            STEP_NB:
            begin
                res  = 64'(pb_reg) + q;
                fail = !rls_pkg::fits32(res);
            end
            STEP_C00, STEP_C01, STEP_C10, STEP_C11:
            begin
                res  = q;
                fail = !rls_pkg::fits32(q);
            end
            default:
            begin
                res  = q;
                fail = 1'b0;
            end
        endcase
        nsum = 64'(n01_reg) + 64'(n10_reg);
    end

    assign do_post = (state_reg == ST_POST) ||
                     (state_reg == ST_ISSUE && is_chk) ||
                     (state_reg == ST_WAIT && div_done);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_IDLE;
            step_reg       <= '0;
            restart_reg    <= 1'b0;
            reject_reg     <= 1'b0;
            forget_reg     <= rls_pkg::FORGET_RESET;
            initcov_reg    <= rls_pkg::INITCOV_RESET;
            minden_reg     <= rls_pkg::MINDEN_RESET;
            pa_reg         <= '0;
            pb_reg         <= '0;
            cda_reg        <= $signed({1'b0, rls_pkg::INITCOV_RESET});
            cod_reg        <= '0;
            cdb_reg        <= $signed({1'b0, rls_pkg::INITCOV_RESET});
            out_valid_reg  <= 1'b0;
            out_pred_reg   <= '0;
            out_err_reg    <= '0;
            out_ea_reg     <= '0;
            out_eb_reg     <= '0;
            out_status_reg <= 1'b0;
        end
        else
        begin
            if (cfg_valid)
            begin
                unique case (cfg_index)
                    rls_pkg::CFG_FORGET:  forget_reg  <= cfg_data[16:0];
                    rls_pkg::CFG_INITCOV: initcov_reg <= cfg_data;
                    rls_pkg::CFG_MINDEN:  minden_reg  <= cfg_data[16:0];
                    default: ;
                endcase
            end

            if (out_valid_reg && m_tready)
                out_valid_reg <= 1'b0;

            if (do_post)
            begin
                unique case (step_reg)
                    STEP_PRED:
                    begin
                        pred_reg <= sum[31:0];
                        err_reg  <= errw[31:0];
                    end
                    STEP_P0:  p0_reg  <= res[31:0];
                    STEP_P1:  p1_reg  <= res[31:0];
                    STEP_D,
                    STEP_CHK: d_reg   <= res[31:0];
                    STEP_G0:  g0_reg  <= res[31:0];
                    STEP_G1:  g1_reg  <= res[31:0];
                    STEP_NA:  na_reg  <= res[31:0];
                    STEP_NB:  nb_reg  <= res[31:0];
                    STEP_C00: c00_reg <= res[31:0];
                    STEP_C01: c01_reg <= res[31:0];
                    STEP_C10: c10_reg <= res[31:0];
                    STEP_C11: c11_reg <= res[31:0];
                    STEP_N00: n00_reg <= res[31:0];
                    STEP_N01: n01_reg <= res[31:0];
                    STEP_N10: n10_reg <= res[31:0];
                    STEP_N11: n11_reg <= res[31:0];
                    default:  acc_reg <= q;
                endcase
            end

            unique case (state_reg)
                ST_IDLE:
                begin
                    if (accept)
                    begin
                        a_reg       <= $signed(s_tdata[31:0]);
                        b_reg       <= $signed(s_tdata[63:32]);
                        y_reg       <= $signed(s_tdata[95:64]);
                        step_reg    <= '0;
                        restart_reg <= s_tuser[0];
                        reject_reg  <= (forget_reg == 17'd0) ||
                                       (forget_reg > rls_pkg::FORGET_MAX);
                        if (s_tuser[0] || forget_reg == 17'd0 ||
                            forget_reg > rls_pkg::FORGET_MAX)
                            state_reg <= ST_FIN;
                        else
                            state_reg <= ST_ISSUE;
                    end
                end
                ST_ISSUE:
                begin
                    if (is_div)
                        state_reg <= ST_WAIT;
                    else if (!is_chk)
                        state_reg <= ST_POST;
                end
                ST_POST, ST_WAIT: ;
                ST_FIN:
                begin
                    if (!out_valid_reg || m_tready)
                    begin
                        out_valid_reg <= 1'b1;
                        state_reg     <= ST_IDLE;
                        if (restart_reg)
                        begin
                            pa_reg         <= '0;
                            pb_reg         <= '0;
                            cda_reg        <= $signed({1'b0, initcov_reg});
                            cod_reg        <= '0;
                            cdb_reg        <= $signed({1'b0, initcov_reg});
                            out_pred_reg   <= '0;
                            out_err_reg    <= '0;
                            out_status_reg <= 1'b0;
                            out_ea_reg     <= '0;
                            out_eb_reg     <= '0;
                        end
                        else if (reject_reg)
                        begin
                            out_pred_reg   <= '0;
                            out_err_reg    <= '0;
                            out_status_reg <= 1'b1;
                            out_ea_reg     <= pa_reg;
                            out_eb_reg     <= pb_reg;
                        end
                        else
                        begin
                            pa_reg         <= na_reg;
                            pb_reg         <= nb_reg;
                            cda_reg        <= n00_reg;
                            // Off-diagonal is the floor of the mean of both halves.
                            cod_reg        <= nsum[32:1];
                            cdb_reg        <= n11_reg;
                            out_pred_reg   <= pred_reg;
                            out_err_reg    <= err_reg;
                            out_status_reg <= 1'b0;
                            out_ea_reg     <= na_reg;
                            out_eb_reg     <= nb_reg;
                        end
                    end
                end
                default: state_reg <= ST_IDLE;
            endcase

            // Any failed range check ends the update; the state is committed only in ST_FIN.
            if (do_post)
            begin
                if (fail)
                begin
                    reject_reg <= 1'b1;
                    state_reg  <= ST_FIN;
                end
                else if (step_reg == STEP_N11)
                begin
                    state_reg <= ST_FIN;
                end
                else
                begin
                    step_reg  <= step_reg + 1'b1;
                    state_reg <= ST_ISSUE;
                end
            end
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {out_eb_reg, out_ea_reg, out_err_reg, out_pred_reg};
    assign m_tuser  = out_status_reg;

    property p_div_done_in_wait;
        @(posedge clk) disable iff (!rst_n) div_done |-> (state_reg == ST_WAIT);
    endproperty
    a_div_done_in_wait: assert property (p_div_done_in_wait)
        else $error("divider finished outside of a wait step");

    property p_reject_zeroes;
        @(posedge clk) disable iff (!rst_n)
            (m_tvalid && m_tuser[0]) |-> (m_tdata[63:0] == 64'd0);
    endproperty
    a_reject_zeroes: assert property (p_reject_zeroes)
        else $error("rejected result carries a prediction");

    property p_busy_after_accept;
        @(posedge clk) disable iff (!rst_n) accept |=> !s_tready;
    endproperty
    a_busy_after_accept: assert property (p_busy_after_accept)
        else $error("input ready right after a request was taken");

endmodule

`default_nettype wire

// File: hw/rtl/rls_mul.sv
// Shared 32x32 signed multiplier with registered product and fixed-point rounding.
// Standalone; instantiated by rls_two_parameter_estimator.
`default_nettype none

module rls_mul #(
    parameter int FRAC_BITS = 16
) (
    input  wire logic               clk,
    input  wire logic signed [31:0] x,
    input  wire logic signed [31:0] y,
    output logic signed [63:0]      q
);

    localparam logic signed [63:0] RND = 64'sd1 <<< (FRAC_BITS - 1);

    logic signed [63:0] prod_reg;

    always_ff @(posedge clk)
    begin
        prod_reg <= x * y;
    end

    // Round to nearest with ties upward, then floor shift.
    assign q = (prod_reg + RND) >>> FRAC_BITS;

endmodule

`default_nettype wire

// File: hw/rtl/rls_div.sv
// Restoring signed divider, one quotient bit per cycle, truncation toward zero.
// Depends on rls_pkg for the request struct and widths.
`default_nettype none

module rls_div (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire rls_pkg::div_req_t req,
    output logic                   done,
    output logic signed [rls_pkg::DIV_W-1:0] quotient
);

    logic [rls_pkg::DIV_W-1:0]   sh_reg;
    logic [31:0]                 rem_reg;
    logic [31:0]                 dmag_reg;
    logic                        neg_reg;
    logic                        busy_reg;
    logic                        done_reg;
    logic [rls_pkg::DIV_CNT-1:0] cnt_reg;

    logic [32:0]               trial;
    logic                      qbit;
    logic [32:0]               dabs;
    logic [rls_pkg::DIV_W-1:0] nabs;

    assign trial = {rem_reg, sh_reg[rls_pkg::DIV_W-1]};
    assign qbit  = trial >= {1'b0, dmag_reg};
    assign dabs  = req.divisor[31] ? -{req.divisor[31], req.divisor}
                                   : {req.divisor[31], req.divisor};
    assign nabs  = req.dividend[rls_pkg::DIV_W-1] ? -req.dividend : req.dividend;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
            sh_reg   <= '0;
            rem_reg  <= '0;
            dmag_reg <= '0;
            neg_reg  <= 1'b0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (req.start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= rls_pkg::DIV_CNT'(rls_pkg::DIV_W);
                sh_reg   <= nabs;
                rem_reg  <= '0;
                dmag_reg <= dabs[31:0];
                neg_reg  <= req.dividend[rls_pkg::DIV_W-1] ^ req.divisor[31];
            end
            else if (busy_reg)
            begin
                rem_reg <= qbit ? 32'(trial - {1'b0, dmag_reg}) : trial[31:0];
                sh_reg  <= {sh_reg[rls_pkg::DIV_W-2:0], qbit};
                cnt_reg <= cnt_reg - 1'b1;
                if (cnt_reg == rls_pkg::DIV_CNT'(1))
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    assign done     = done_reg;
    assign quotient = neg_reg ? -$signed(sh_reg) : $signed(sh_reg);

endmodule

`default_nettype wire
